// ----- rtl/spi_mbt_pkg.sv -----
// package for the spi master byte transfer block
// types, constants and helper functions used by all rtl files but the checker; no dependencies
`default_nettype none

package spi_mbt_pkg;

  localparam int WORD_BITS  = 8;
  localparam int IDX_W      = $clog2(WORD_BITS);
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WORD_BITS - 1);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETUP  = 2'd1,
    PH_SAMPLE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] spi_mode;
    logic       low_bit_first;
    logic [7:0] half_period_ticks;
  } cfg_t;

  // idle clock update that goes with a configuration write
  typedef struct packed {
    logic we;
    logic cpol;
  } cfg_upd_t;

  typedef struct packed {
    logic                 sck;
    logic                 mosi;
    logic                 busy_res;
    logic [WORD_BITS-1:0] rx_byte;
    logic                 done_res;
  } result_t;

  // shift register position of bit number idx
  function automatic logic [IDX_W-1:0] bit_pos(input logic [IDX_W-1:0] idx,
                                               input logic lsb);
    return lsb ? idx : (LAST_BIT - idx);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spi_mbt_if.sv -----
// item channels of the spi master byte transfer block
// valid/ready handshake with payload fields; uses spi_mbt_pkg
`default_nettype none

interface spi_mbt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              start_req;
  logic [spi_mbt_pkg::WORD_BITS-1:0] tx_byte;
  logic                              miso;

  modport source (output valid, start_req, tx_byte, miso, input ready);
  modport sink   (input valid, start_req, tx_byte, miso, output ready);
endinterface

interface spi_mbt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              sck;
  logic                              mosi;
  logic                              busy_res;
  logic [spi_mbt_pkg::WORD_BITS-1:0] rx_byte;
  logic                              done_res;

  modport source (output valid, sck, mosi, busy_res, rx_byte, done_res, input ready);
  modport sink   (input valid, sck, mosi, busy_res, rx_byte, done_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/spi_mbt_engine.sv -----
// serial engine: bit sequencer state and the next-state / result logic
// uses spi_mbt_pkg
`default_nettype none

module spi_mbt_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              step,
  input  wire logic                              start_req,
  input  wire logic [spi_mbt_pkg::WORD_BITS-1:0] tx_byte,
  input  wire logic                              miso,
  input  wire spi_mbt_pkg::cfg_t                 cfg,
  input  wire spi_mbt_pkg::cfg_upd_t             cfg_upd,
  output spi_mbt_pkg::result_t                   res
);

  logic [spi_mbt_pkg::WORD_BITS-1:0] out_shift, out_shift_next;
  logic [spi_mbt_pkg::WORD_BITS-1:0] in_shift, in_shift_next;
  logic [spi_mbt_pkg::IDX_W-1:0]     bit_index, bit_index_next;
  spi_mbt_pkg::phase_t               bit_phase, bit_phase_next;
  logic [7:0]                        wait_count, wait_count_next;
  logic                              clock_level, clock_level_next;
  logic                              data_level, data_level_next;
  logic                              active, active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_shift   <= '0;
      in_shift    <= '0;
      bit_index   <= '0;
      bit_phase   <= spi_mbt_pkg::PH_IDLE;
      wait_count  <= '0;
      clock_level <= 1'b0;
      data_level  <= 1'b0;
      active      <= 1'b0;
    end else if (step) begin
      out_shift   <= out_shift_next;
      in_shift    <= in_shift_next;
      bit_index   <= bit_index_next;
      bit_phase   <= bit_phase_next;
      wait_count  <= wait_count_next;
      clock_level <= clock_level_next;
      data_level  <= data_level_next;
      active      <= active_next;
    end else if (cfg_upd.we && !active) begin
      clock_level <= cfg_upd.cpol;
    end
  end

  always_comb begin
    logic                              cpol;
    logic                              cpha;
    logic [spi_mbt_pkg::IDX_W-1:0]     pos;
    logic                              do_setup;
    logic [spi_mbt_pkg::WORD_BITS-1:0] setup_word;
    logic [spi_mbt_pkg::IDX_W-1:0]     setup_idx;

    cpol = cfg.spi_mode[1];
    cpha = cfg.spi_mode[0];
    pos  = spi_mbt_pkg::bit_pos(bit_index, cfg.low_bit_first);

    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    bit_index_next   = bit_index;
    bit_phase_next   = bit_phase;
    wait_count_next  = wait_count;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    active_next      = active;
    do_setup         = 1'b0;
    setup_word       = out_shift;
    setup_idx        = bit_index;
    res.rx_byte      = '0;
    res.done_res     = 1'b0;

    if (!active || !(bit_phase == spi_mbt_pkg::PH_SETUP ||
                     bit_phase == spi_mbt_pkg::PH_SAMPLE)) begin
      active_next      = 1'b0;
      bit_phase_next   = spi_mbt_pkg::PH_IDLE;
      clock_level_next = cpol;
      if (start_req) begin
        out_shift_next = tx_byte;
        in_shift_next  = '0;
        bit_index_next = '0;
        active_next    = 1'b1;
        do_setup       = 1'b1;
        setup_word     = tx_byte;
        setup_idx      = '0;
      end
    end else if (wait_count != 8'd0) begin
      wait_count_next = wait_count - 8'd1;
    end else if (bit_phase == spi_mbt_pkg::PH_SETUP) begin
      in_shift_next[pos] = in_shift[pos] | miso;
      clock_level_next   = cpha ? cpol : !cpol;
      bit_phase_next     = spi_mbt_pkg::PH_SAMPLE;
      wait_count_next    = cfg.half_period_ticks;
    end else begin
      clock_level_next = cpol;
      if (bit_index == spi_mbt_pkg::LAST_BIT) begin
        res.done_res   = 1'b1;
        res.rx_byte    = in_shift;
        active_next    = 1'b0;
        bit_phase_next = spi_mbt_pkg::PH_IDLE;
        bit_index_next = '0;
      end else begin
        bit_index_next = bit_index + 1'b1;
        do_setup       = 1'b1;
        setup_idx      = bit_index + 1'b1;
      end
    end

    // setup step: drive the next data bit, first clock edge for cpha 1
    if (do_setup) begin
      data_level_next = setup_word[spi_mbt_pkg::bit_pos(setup_idx, cfg.low_bit_first)];
      if (cpha) begin
        clock_level_next = !cpol;
      end
      bit_phase_next  = spi_mbt_pkg::PH_SETUP;
      wait_count_next = cfg.half_period_ticks;
    end

    res.sck      = clock_level_next;
    res.mosi     = data_level_next;
    res.busy_res = active_next;
  end

endmodule

`default_nettype wire

// ----- rtl/spi_mbt_out_reg.sv -----
// output register of the result channel, loaded on every accepted input item
// uses spi_mbt_pkg and spi_mbt_out_if
`default_nettype none

module spi_mbt_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire spi_mbt_pkg::result_t res,
  output logic                      can_load,
  spi_mbt_out_if.source             out_ch
);

  logic                 valid;
  spi_mbt_pkg::result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  // room when empty or when the held item leaves this cycle
  assign can_load        = !valid || out_ch.ready;
  assign out_ch.valid    = valid;
  assign out_ch.sck      = data.sck;
  assign out_ch.mosi     = data.mosi;
  assign out_ch.busy_res = data.busy_res;
  assign out_ch.rx_byte  = data.rx_byte;
  assign out_ch.done_res = data.done_res;

endmodule

`default_nettype wire

// ----- rtl/spi_master_byte_transfer.sv -----
// top level of the spi master byte transfer block: configuration registers,
// serial engine and result register; uses spi_mbt_pkg, spi_mbt_if, spi_mbt_engine,
// spi_mbt_out_reg
//
// usage
// - in_ch carries one item per serial tick: start_req, tx_byte and the miso level
// - out_ch returns one item per input item: sck, mosi, busy_res, rx_byte, done_res
// - the result of an accepted item is registered and valid in the cycle after it
//   is accepted
// - throughput is one item per cycle while out_ch takes results; the engine state
//   is updated in a single registered pass, so nothing limits the rate but the output register
// - when the receiver stalls, the result stays in the output register and
//   in_ch.ready drops until it is taken; no item is lost or repeated
// - configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
//   edge; a write while idle also moves the idle sck level to the new cpol
// - a write to an index beyond the register list changes no register
// - synchronous reset clears the configuration and engine registers: mode 0,
//   msb first, no wait ticks, idle engine; the result register is left empty
`default_nettype none

module spi_master_byte_transfer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  spi_mbt_in_if.sink                               in_ch,
  spi_mbt_out_if.source                            out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [spi_mbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spi_mbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spi_mbt_pkg::cfg_t     cfg;
  spi_mbt_pkg::cfg_upd_t cfg_upd;
  spi_mbt_pkg::result_t  res;
  logic                  can_load;
  logic                  step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spi_mbt_pkg::CFG_SPI_MODE:    cfg.spi_mode          <= cfg_data[1:0];
        spi_mbt_pkg::CFG_LSB_FIRST:   cfg.low_bit_first     <= cfg_data[0];
        spi_mbt_pkg::CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // idle sck follows the cpol that this write leaves behind
  always_comb begin
    cfg_upd.we   = cfg_we;
    cfg_upd.cpol = (cfg_index == spi_mbt_pkg::CFG_SPI_MODE) ? cfg_data[1]
                                                            : cfg.spi_mode[1];
  end

  // an item is taken whenever the result register has room
  assign in_ch.ready = can_load;
  assign step        = in_ch.valid && can_load;

  spi_mbt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (in_ch.start_req),
    .tx_byte   (in_ch.tx_byte),
    .miso      (in_ch.miso),
    .cfg       (cfg),
    .cfg_upd   (cfg_upd),
    .res       (res)
  );

  spi_mbt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/spi_mbt_checker.sv -----
// port-level checks of the spi master byte transfer block, bound to the top level
// uses no package; sees the top level ports only
`default_nettype none

module spi_mbt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       busy_res,
  input wire logic [7:0] rx_byte,
  input wire logic       done_res
);

  // a finished transfer is never reported busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done_res with busy_res");

  // received byte reads zero outside the done item
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> rx_byte == 8'd0)
    else $error("rx_byte nonzero without done_res");

  // an accepted item shows up as a result at the next edge
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accepted item");

  // an empty result register always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing waits at the output right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind spi_master_byte_transfer spi_mbt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .busy_res  (out_ch.busy_res),
  .rx_byte   (out_ch.rx_byte),
  .done_res  (out_ch.done_res)
);

`default_nettype wire
